@@ design/hck_pkg.sv @@
package hck_pkg;

  localparam int KEY_W = 32;
  localparam int CNT_W = 32;
  localparam int CFG_W = 11;
  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  // status of the remainder unit
  typedef struct packed {
    logic busy;
    logic done;
  } hck_div_stat_t;

endpackage

@@ design/chained_hash_key_counter_core.sv @@
// Insert and lookup run a bit-serial modulo of the key, then read the bucket head
//   and walk the chain, reading one entry per link walked.
// Operations are taken one at a time; clear sweeps the whole bucket head memory.
//   Opcode 3 goes straight to the output without a memory access.
// Reset: synchronous active-low rst_n; afterwards a pass over the head memory
//   empties all bucket heads before the first input transaction is taken.
module chained_hash_key_counter_core #(
  parameter int BUCKETS = 1024,
  parameter int ENTRIES = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [31:0]                in_tdata,  // key
  input  logic [1:0]                 in_tuser,  // opcode
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [hck_pkg::CFG_W-1:0]  cfg_data,  // bucket_count
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [31:0]                out_tdata, // count
  output logic [7:0]                 out_tuser  // found, is_new, full_res, zeros
);
  import hck_pkg::*;

  localparam int EW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int LW  = $clog2(ENTRIES + 1);
  localparam int BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int NW  = $clog2(BUCKETS + 1);
  localparam int EDW = KEY_W + CNT_W + LW;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_MOD  = 3'd2;
  localparam logic [2:0] S_HEAD = 3'd3;
  localparam logic [2:0] S_WALK = 3'd4;
  localparam logic [2:0] S_ENT  = 3'd5;
  localparam logic [2:0] S_CLR  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]       state_r;
  logic [CFG_W-1:0] bcnt_r;
  logic [1:0]       op_r;
  logic [KEY_W-1:0] key_r;
  logic [BW-1:0]    bucket_r;
  logic [LW-1:0]    head_r;
  logic [LW-1:0]    link_r;
  logic [LW-1:0]    steps_r;
  logic [LW-1:0]    used_r;
  logic [BW-1:0]    clr_r;
  logic             res_found_r, res_new_r, res_full_r;
  logic [CNT_W-1:0] res_cnt_r;
  logic             out_valid_r, out_found_r, out_new_r, out_full_r;
  logic [CNT_W-1:0] out_cnt_r;

  logic [NW-1:0]    n_eff;
  logic             div_start;
  hck_div_stat_t    div_stat;
  logic [NW-1:0]    div_rem;

  logic             head_we, head_re;
  logic [BW-1:0]    head_waddr;
  logic [LW-1:0]    head_wdata, head_rdata;
  logic             ent_we, ent_re;
  logic [EW-1:0]    ent_waddr, ent_raddr;
  logic [EDW-1:0]   ent_wdata, ent_rdata;
  logic [KEY_W-1:0] ent_key;
  logic [CNT_W-1:0] ent_cnt, ent_inc;
  logic [LW-1:0]    ent_next;
  logic             link_end, in_acc, out_load;

  // clamp the configured bucket count to 1..BUCKETS
  always_comb begin
    if (bcnt_r == '0) begin
      n_eff = NW'(1);
    end else if (32'(bcnt_r) > 32'(BUCKETS)) begin
      n_eff = NW'(BUCKETS);
    end else begin
      n_eff = NW'(bcnt_r);
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign div_start = in_acc && (in_tuser == OP_INSERT || in_tuser == OP_LOOKUP);

  hck_mod #(.NW(NW)) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .key   (in_tdata),
    .n     (n_eff),
    .stat  (div_stat),
    .rem   (div_rem)
  );

  hck_ram #(.W(LW), .D(BUCKETS)) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (head_wdata),
    .re    (head_re),
    .raddr (BW'(div_rem)),
    .rdata (head_rdata)
  );

  hck_ram #(.W(EDW), .D(ENTRIES)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .re    (ent_re),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  assign ent_key  = ent_rdata[EDW-1 -: KEY_W];
  assign ent_cnt  = ent_rdata[LW +: CNT_W];
  assign ent_next = ent_rdata[LW-1:0];
  assign ent_inc  = (ent_cnt == '1) ? ent_cnt : ent_cnt + 1'b1;
  assign link_end = (link_r == '0) || (link_r > LW'(ENTRIES)) || (steps_r >= LW'(ENTRIES));
  assign ent_raddr = EW'(link_r - 1'b1);
  assign head_re   = div_stat.done;
  assign ent_re    = (state_r == S_WALK) && !link_end;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_tready);

  // memory write selection
  always_comb begin
    head_we    = 1'b0;
    head_waddr = bucket_r;
    head_wdata = LW'(used_r + 1'b1);
    ent_we     = 1'b0;
    ent_waddr  = EW'(used_r);
    ent_wdata  = {key_r, CNT_W'(1), head_r};
    case (state_r)
      S_INIT, S_CLR: begin
        head_we    = 1'b1;
        head_waddr = clr_r;
        head_wdata = '0;
      end
      S_WALK: begin
        if (link_end && op_r == OP_INSERT && used_r < LW'(ENTRIES)) begin
          head_we = 1'b1;
          ent_we  = 1'b1;
        end
      end
      S_ENT: begin
        if (ent_key == key_r && op_r == OP_INSERT) begin
          ent_we    = 1'b1;
          ent_waddr = EW'(link_r - 1'b1);
          ent_wdata = {ent_key, ent_inc, ent_next};
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      clr_r   <= '0;
      used_r  <= '0;
      bcnt_r  <= CFG_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        bcnt_r <= cfg_data;
      end
      case (state_r)
        S_INIT, S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == BW'(BUCKETS - 1)) begin
            clr_r   <= '0;
            used_r  <= '0;
            state_r <= (state_r == S_INIT) ? S_IDLE : S_DONE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            if (div_start) begin
              state_r <= S_MOD;
            end else if (in_tuser == OP_CLEAR) begin
              state_r <= S_CLR;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_MOD: begin
          if (div_stat.done) begin
            state_r <= S_HEAD;
          end
        end
        S_HEAD: state_r <= S_WALK;
        S_WALK: begin
          if (link_end) begin
            if (op_r == OP_INSERT && used_r < LW'(ENTRIES)) begin
              used_r <= used_r + 1'b1;
            end
            state_r <= S_DONE;
          end else begin
            state_r <= S_ENT;
          end
        end
        S_ENT: state_r <= (ent_key == key_r) ? S_DONE : S_WALK;
        S_DONE: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // operation datapath and result assembly
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        op_r        <= in_tuser;
        key_r       <= in_tdata;
        res_found_r <= 1'b0;
        res_new_r   <= 1'b0;
        res_full_r  <= 1'b0;
        res_cnt_r   <= '0;
      end
      S_MOD: bucket_r <= BW'(div_rem);
      S_HEAD: begin
        head_r  <= head_rdata;
        link_r  <= head_rdata;
        steps_r <= '0;
      end
      S_WALK: begin
        if (link_end && op_r == OP_INSERT) begin
          if (used_r < LW'(ENTRIES)) begin
            res_new_r <= 1'b1;
            res_cnt_r <= CNT_W'(1);
          end else begin
            res_full_r <= 1'b1;
          end
        end
      end
      S_ENT: begin
        if (ent_key == key_r) begin
          res_found_r <= 1'b1;
          res_cnt_r   <= (op_r == OP_INSERT) ? ent_inc : ent_cnt;
        end else begin
          link_r  <= ent_next;
          steps_r <= steps_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // output register: hold until the transaction completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found_r <= res_found_r;
      out_new_r   <= res_new_r;
      out_full_r  <= res_full_r;
      out_cnt_r   <= res_cnt_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_cnt_r;
  assign out_tuser  = {5'b0, out_full_r, out_new_r, out_found_r};

  a_new_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_found_r && out_new_r))
    else $error("result both found and new");
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_full_r) |-> (out_cnt_r == '0))
    else $error("dropped insert carries a count");
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= LW'(ENTRIES))
    else $error("entry count beyond capacity");
  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == S_MOD))
    else $error("remainder ready outside modulo phase");
endmodule

@@ design/hck_ram.sv @@
module hck_ram #(
  parameter int W = 32,
  parameter int D = 1024
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                        wdata,
  input  logic                                re,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                        rdata
);
  logic [W-1:0] mem [D];

  // write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

@@ design/hck_mod.sv @@
module hck_mod #(
  parameter int NW = 11
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [hck_pkg::KEY_W-1:0]  key,
  input  logic [NW-1:0]              n,
  output hck_pkg::hck_div_stat_t     stat,
  output logic [NW-1:0]              rem
);
  import hck_pkg::*;

  localparam int CW = $clog2(KEY_W);

  logic [NW-1:0]    rem_r, rem_nxt;
  logic [KEY_W-1:0] key_r;
  logic [NW-1:0]    n_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r, done_r;
  logic [NW:0]      trial;

  // one restoring step: shift in the next key bit, subtract if it fits
  always_comb begin
    trial = {rem_r, key_r[KEY_W-1]};
    if (trial >= {1'b0, n_r}) begin
      rem_nxt = NW'(trial - {1'b0, n_r});
    end else begin
      rem_nxt = NW'(trial);
    end
  end

  // control: one key bit per cycle, most significant first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(KEY_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      rem_r <= '0;
      key_r <= key;
      n_r   <= n;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      key_r <= {key_r[KEY_W-2:0], 1'b0};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign rem       = rem_r;
endmodule
